[src/gfs_pkg.sv]
// Shared types and constants for the grayscale frame serializer.
package gfs_pkg;

   // Command codes carried on req_cmd.
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Blank-low length after reset, in ticks.
   localparam logic [15:0] BLANK_RESET = 16'd4096;

   typedef enum logic [2:0] {
      PH_START      = 3'd0,
      PH_SHIFT_LO   = 3'd1,
      PH_SHIFT_HI   = 3'd2,
      PH_LATCH      = 3'd3,
      PH_BLANK_LOW  = 3'd4,
      PH_BLANK_HIGH = 3'd5
   } phase_type;

   // Pin step decided for one tick, before the serial bit is known.
   typedef struct packed {
      logic shift;
      logic hit;
      logic sclk;
      logic latch;
      logic blank;
      logic fend;
   } step_type;

endpackage

[src/gfs_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module gfs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/gfs_sequencer.sv]
// Frame loop sequencer: phase, bit counters, level banks and RAM access.
module gfs_sequencer #(
   parameter int CHANNELS   = 16,
   parameter int LEVEL_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick_go,
   input  logic                               set_go,
   input  logic [3:0]                         req_channel,
   input  logic [LEVEL_BITS-1:0]              req_level,
   input  logic [15:0]                        blank_low_ticks,
   output logic                               ram_we,
   output logic [$clog2(CHANNELS):0]          ram_waddr,
   output logic [LEVEL_BITS-1:0]              ram_wdata,
   output logic                               ram_re,
   output logic [$clog2(CHANNELS):0]          ram_raddr,
   output gfs_pkg::step_type                  step,
   output logic [$clog2(LEVEL_BITS)-1:0]      step_pos
);
   import gfs_pkg::*;

   localparam int CH_W  = $clog2(CHANNELS);
   localparam int SLOTS = 1 << CH_W;
   localparam int AW    = CH_W + 1;
   localparam int PW    = $clog2(LEVEL_BITS);
   localparam logic [PW-1:0]   LAST_POS = PW'(LEVEL_BITS - 1);
   localparam logic [CH_W-1:0] LAST_CH  = CH_W'(CHANNELS - 1);

   // Each channel has two RAM slots. The captured image lives in the slot
   // named by snap, new levels go to the other one, so a set never touches
   // what is being shifted out.
   phase_type          phase_ff, phase_in;
   logic               changed_ff, changed_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic [SLOTS-1:0]   snap_ff, snap_in;
   logic [SLOTS-1:0]   latest_ff, latest_in;
   logic [2*SLOTS-1:0] valid_ff, valid_in;

   phase_type          eff_phase;
   logic               capture;
   logic [CH_W-1:0]    eff_ch;
   logic [PW-1:0]      eff_pos;
   logic [15:0]        eff_cnt;
   logic [15:0]        cnt_inc;
   logic [CH_W+3:0]    set_ch_ext;
   logic               set_ok;
   logic [CH_W-1:0]    set_ch;
   logic [AW-1:0]      waddr;
   logic [AW-1:0]      raddr;
   step_type           step_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         changed_ff <= 1'b0;
         ch_ff      <= '0;
         pos_ff     <= '0;
         cnt_ff     <= '0;
         snap_ff    <= '0;
         latest_ff  <= '0;
         valid_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         changed_ff <= changed_in;
         ch_ff      <= ch_in;
         pos_ff     <= pos_in;
         cnt_ff     <= cnt_in;
         snap_ff    <= snap_in;
         latest_ff  <= latest_in;
         valid_ff   <= valid_in;
      end
   end

   always_comb begin
      eff_phase = phase_ff;
      capture   = 1'b0;
      eff_ch    = ch_ff;
      eff_pos   = pos_ff;
      eff_cnt   = cnt_ff;
      case (phase_ff)
         PH_SHIFT_LO, PH_SHIFT_HI, PH_LATCH, PH_BLANK_LOW, PH_BLANK_HIGH: begin
            eff_phase = phase_ff;
         end
         default: begin
            if (changed_ff) begin
               capture   = 1'b1;
               eff_phase = PH_SHIFT_LO;
               eff_ch    = '0;
               eff_pos   = LAST_POS;
            end else begin
               eff_phase = PH_BLANK_LOW;
               eff_cnt   = '0;
            end
         end
      endcase

      raddr = {(capture ? latest_ff[0] : snap_ff[ch_ff]), eff_ch};

      step_c.shift = 1'b0;
      step_c.hit   = valid_ff[raddr];
      step_c.sclk  = 1'b0;
      step_c.latch = 1'b0;
      step_c.blank = 1'b1;
      step_c.fend  = 1'b0;
      cnt_inc      = eff_cnt + 16'd1;

      phase_in   = phase_ff;
      changed_in = changed_ff;
      ch_in      = ch_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      snap_in    = snap_ff;
      latest_in  = latest_ff;
      valid_in   = valid_ff;

      case (eff_phase)
         PH_SHIFT_LO: begin
            step_c.shift = 1'b1;
            phase_in     = PH_SHIFT_HI;
            ch_in        = eff_ch;
            pos_in       = eff_pos;
         end
         PH_SHIFT_HI: begin
            step_c.shift = 1'b1;
            step_c.sclk  = 1'b1;
            if (eff_pos != '0) begin
               pos_in   = eff_pos - PW'(1);
               phase_in = PH_SHIFT_LO;
            end else if (eff_ch != LAST_CH) begin
               ch_in    = eff_ch + CH_W'(1);
               pos_in   = LAST_POS;
               phase_in = PH_SHIFT_LO;
            end else begin
               ch_in    = '0;
               pos_in   = '0;
               phase_in = PH_LATCH;
            end
         end
         PH_LATCH: begin
            step_c.latch = 1'b1;
            cnt_in       = '0;
            phase_in     = PH_BLANK_LOW;
         end
         PH_BLANK_LOW: begin
            step_c.blank = 1'b0;
            if (cnt_inc >= blank_low_ticks) begin
               cnt_in   = '0;
               phase_in = PH_BLANK_HIGH;
            end else begin
               cnt_in   = cnt_inc;
               phase_in = PH_BLANK_LOW;
            end
         end
         default: begin
            step_c.fend = 1'b1;
            phase_in    = PH_START;
         end
      endcase

      if (capture) begin
         changed_in = 1'b0;
         snap_in    = latest_ff;
      end

      // Ticks and sets never arrive in the same cycle.
      if (!tick_go) begin
         phase_in   = phase_ff;
         changed_in = changed_ff;
         ch_in      = ch_ff;
         pos_in     = pos_ff;
         cnt_in     = cnt_ff;
         snap_in    = snap_ff;
      end

      set_ch_ext = (CH_W + 4)'(req_channel);
      set_ok     = set_go && (set_ch_ext < (CH_W + 4)'(CHANNELS));
      set_ch     = set_ch_ext[CH_W-1:0];
      waddr      = {~snap_ff[set_ch], set_ch};
      if (set_ok) begin
         changed_in        = 1'b1;
         latest_in[set_ch] = ~snap_ff[set_ch];
         valid_in[waddr]   = 1'b1;
      end
   end

   assign ram_we    = set_ok;
   assign ram_waddr = waddr;
   assign ram_wdata = req_level;
   assign ram_re    = tick_go && step_c.shift;
   assign ram_raddr = raddr;
   assign step      = step_c;
   assign step_pos  = eff_pos;

endmodule

[src/gfs_out_stage.sv]
// Read-data stage and result register with the result channel handshake.
module gfs_out_stage #(
   parameter int LEVEL_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_go,
   input  gfs_pkg::step_type             step,
   input  logic [$clog2(LEVEL_BITS)-1:0] step_pos,
   input  logic [LEVEL_BITS-1:0]         rd_data,
   input  logic                          rsp_stall,
   output logic                          s1_free,
   output logic                          rsp_valid,
   output logic                          rsp_serial_data,
   output logic                          rsp_serial_clock,
   output logic                          rsp_latch_pulse,
   output logic                          rsp_blank_out,
   output logic                          rsp_frame_end
);
   import gfs_pkg::*;

   localparam int PW = $clog2(LEVEL_BITS);

   logic          s1_valid_ff, s1_valid_in;
   step_type      s1_step_ff;
   logic [PW-1:0] s1_pos_ff;
   logic          out_valid_ff, out_valid_in;
   logic          sdata_ff, sclk_ff, latch_ff, blank_ff, fend_ff;
   logic          out_free;
   logic          s1_move;
   logic          s1_bit;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;

   // The RAM read data belongs to the item in the first stage; a slot
   // that was never written reads as zero.
   assign s1_bit = s1_step_ff.shift && s1_step_ff.hit && rd_data[s1_pos_ff];

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
      if (s1_free) begin
         s1_valid_in = step_go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         s1_step_ff <= step;
         s1_pos_ff  <= step_pos;
      end
      if (s1_move) begin
         sdata_ff <= s1_bit;
         sclk_ff  <= s1_step_ff.sclk;
         latch_ff <= s1_step_ff.latch;
         blank_ff <= s1_step_ff.blank;
         fend_ff  <= s1_step_ff.fend;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_serial_data  = sdata_ff;
   assign rsp_serial_clock = sclk_ff;
   assign rsp_latch_pulse  = latch_ff;
   assign rsp_blank_out    = blank_ff;
   assign rsp_frame_end    = fend_ff;

endmodule

[src/grayscale_frame_serializer.sv]
// Top level of the grayscale frame serializer.
//
//   channel | direction | handshake              | beat carries
//   req_    | in        | req_valid / req_stall  | cmd, channel, level
//   rsp_    | out       | rsp_valid / rsp_stall  | serial_data, serial_clock, latch_pulse,
//           |           |                        | blank_out, frame_end
//   csr_    | in        | csr_valid / csr_ready  | blank_low_ticks
//
// One beat is accepted per cycle while req_stall is low; a tick's result passes through the
// first stage (sequencer and RAM read) and then the result register.
// Levels sit in one RAM of 2 << $clog2(CHANNELS) slots with one write and one read port.
// Reset is synchronous; per-slot valid bits make unwritten slots read as zero,
// so no clearing pass is needed.
// req_stall rises only while both internal stages are full and rsp_stall is high.
module grayscale_frame_serializer #(
   parameter int CHANNELS   = 16,
   parameter int LEVEL_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [3:0]            req_channel,
   input  logic [LEVEL_BITS-1:0] req_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_serial_data,
   output logic                  rsp_serial_clock,
   output logic                  rsp_latch_pulse,
   output logic                  rsp_blank_out,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_blank_low_ticks
);
   import gfs_pkg::*;

   localparam int AW = $clog2(CHANNELS) + 1;
   localparam int PW = $clog2(LEVEL_BITS);

   logic [15:0]           blank_ticks_ff, blank_ticks_in;
   logic                  s1_free;
   logic                  accept;
   logic                  tick_go;
   logic                  set_go;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [LEVEL_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [LEVEL_BITS-1:0] ram_rdata;
   step_type              step;
   logic [PW-1:0]         step_pos;

   assign csr_ready = 1'b1;
   assign blank_ticks_in = (csr_valid && csr_ready) ? csr_blank_low_ticks : blank_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ticks_ff <= BLANK_RESET;
      end else begin
         blank_ticks_ff <= blank_ticks_in;
      end
   end

   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;
   assign tick_go   = accept && (req_cmd == CMD_TICK);
   assign set_go    = accept && (req_cmd == CMD_SET);

   gfs_sequencer #(
      .CHANNELS   (CHANNELS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .tick_go         (tick_go),
      .set_go          (set_go),
      .req_channel     (req_channel),
      .req_level       (req_level),
      .blank_low_ticks (blank_ticks_ff),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .step            (step),
      .step_pos        (step_pos)
   );

   gfs_ram #(
      .WIDTH (LEVEL_BITS),
      .DEPTH (1 << AW)
   ) u_level_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   gfs_out_stage #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_out (
      .clock            (clock),
      .reset            (reset),
      .step_go          (tick_go),
      .step             (step),
      .step_pos         (step_pos),
      .rd_data          (ram_rdata),
      .rsp_stall        (rsp_stall),
      .s1_free          (s1_free),
      .rsp_valid        (rsp_valid),
      .rsp_serial_data  (rsp_serial_data),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_latch_pulse  (rsp_latch_pulse),
      .rsp_blank_out    (rsp_blank_out),
      .rsp_frame_end    (rsp_frame_end)
   );

`ifndef SYNTHESIS
   // The captured slot and the slot being written are always different.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("level RAM read and write hit the same slot");

   // A serial clock high beat never coincides with blanking released or a latch.
   a_sclk_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_serial_clock) |-> (rsp_blank_out && !rsp_latch_pulse))
      else $error("serial clock outside the shift phase");

   // Latch and end of pass are distinct ticks.
   a_latch_fend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_latch_pulse && rsp_frame_end))
      else $error("latch pulse on the frame end tick");

   // A RAM read is only issued for a tick that enters the first stage.
   a_read_tick: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (tick_go && step.shift))
      else $error("RAM read without a shift tick");
`endif

endmodule
